// ===== rtl/core/deq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue core.
// No dependencies; imported by the controller, datapath, top level and bench.
package deq_pkg;

  // Default sizing, used as the defaults of the top level parameters.
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the command and result fields.
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REPORT     = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_POP_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DONE
  } deq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // update pointers, write the slot on a push
    logic read;   // read both end slots of the ring
  } deq_cmd_t;

endpackage

// ===== rtl/core/deq_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== rtl/core/deq_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the double-ended queue core.
// Depends on deq_pkg for the state type and the datapath command struct.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output deq_pkg::deq_cmd_t dp_cmd
);

  import deq_pkg::*;

  deq_state_t state;
  deq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = 1'b0;
    done        = 1'b0;
    dp_cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          dp_cmd.load = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy        = 1'b1;
        dp_cmd.exec = 1'b1;
        state_next  = ST_READ;
      end
      ST_READ: begin
        busy        = 1'b1;
        dp_cmd.read = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        // Result is shown this cycle; a new request may enter at its end.
        done = 1'b1;
        if (start) begin
          dp_cmd.load = 1'b1;
          state_next  = ST_EXEC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/deq_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the double-ended queue core: ring pointers, count, direction
// bit, status, and the slot RAM. Depends on deq_pkg and deq_ram.
module deq_dp #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  deq_pkg::deq_cmd_t             dp_cmd,
  input  logic [deq_pkg::CMD_W-1:0]     command,
  input  logic [deq_pkg::VALUE_W-1:0]   data_value,
  output logic [deq_pkg::VALUE_W-1:0]   front_value,
  output logic [deq_pkg::VALUE_W-1:0]   back_value,
  output logic [$clog2(DEPTH+1)-1:0]    entry_count,
  output logic                          is_empty,
  output logic [deq_pkg::STATUS_W-1:0]  status
);

  import deq_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam int SumW = CntW + 1;
  localparam int ExtW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  // Captured request (payload, no reset).
  logic [CMD_W-1:0]      cmd_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [STATUS_W-1:0]   status_q;

  // Queue state.
  logic [PtrW-1:0] head;
  logic [CntW-1:0] count;
  logic            rev;

  logic [PtrW-1:0] head_next;
  logic [CntW-1:0] count_next;
  logic            rev_next;
  logic [STATUS_W-1:0] status_next;

  logic            ram_we;
  logic [PtrW-1:0] ram_waddr;
  logic [DATA_WIDTH-1:0] rdata_first;
  logic [DATA_WIDTH-1:0] rdata_last;

  logic [ExtW-1:0] val_ext;
  logic [ExtW-1:0] first_ext;
  logic [ExtW-1:0] last_ext;

  logic [PtrW-1:0] head_dec;
  logic [PtrW-1:0] head_inc;
  logic [SumW-1:0] tail_sum;
  logic [SumW-1:0] last_sum;
  logic [PtrW-1:0] tail_slot;
  logic [PtrW-1:0] last_slot;
  logic            full;
  logic            empty;
  logic            at_first;

  assign val_ext = ExtW'(data_value);

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_q <= command;
      val_q <= val_ext[DATA_WIDTH-1:0];
    end
    if (dp_cmd.exec) begin
      status_q <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else if (dp_cmd.exec) begin
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

  // Ring arithmetic: on a non-empty queue the sums stay below twice the depth,
  // so one compare and subtract wraps them.
  assign head_dec = (head == '0) ? PtrW'(DEPTH - 1) : head - PtrW'(1);
  assign head_inc = (head == PtrW'(DEPTH - 1)) ? '0 : head + PtrW'(1);

  always_comb begin
    tail_sum = SumW'(head) + SumW'(count);
    if (tail_sum >= SumW'(DEPTH)) begin
      tail_sum = tail_sum - SumW'(DEPTH);
    end
    last_sum = SumW'(head) + SumW'(count) - SumW'(1);
    if (last_sum >= SumW'(DEPTH)) begin
      last_sum = last_sum - SumW'(DEPTH);
    end
  end

  assign tail_slot = tail_sum[PtrW-1:0];
  assign last_slot = last_sum[PtrW-1:0];
  assign full      = (count == CntW'(DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    head_next   = head;
    count_next  = count;
    rev_next    = rev;
    status_next = STAT_DONE;
    ram_we      = 1'b0;
    ram_waddr   = tail_slot;
    at_first    = 1'b0;
    unique case (cmd_q) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        at_first = (cmd_q == CMD_PUSH_FRONT) != rev;
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          ram_we     = dp_cmd.exec;
          count_next = count + CntW'(1);
          if (at_first) begin
            head_next = head_dec;
            ram_waddr = head_dec;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        at_first = (cmd_q == CMD_POP_FRONT) != rev;
        if (empty) begin
          status_next = STAT_POP_EMPTY;
        end else begin
          count_next = count - CntW'(1);
          if (at_first) begin
            head_next = head_inc;
          end
        end
      end
      CMD_REVERSE: begin
        rev_next = ~rev;
      end
      default: begin
        // Report only; unused codes behave the same.
      end
    endcase
  end

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (val_q),
    .re      (dp_cmd.read),
    .raddr_a (head),
    .raddr_b (last_slot),
    .rdata_a (rdata_first),
    .rdata_b (rdata_last)
  );

  assign first_ext = ExtW'(rdata_first);
  assign last_ext  = ExtW'(rdata_last);

  always_comb begin
    if (empty) begin
      front_value = '0;
      back_value  = '0;
    end else if (rev) begin
      front_value = last_ext[VALUE_W-1:0];
      back_value  = first_ext[VALUE_W-1:0];
    end else begin
      front_value = first_ext[VALUE_W-1:0];
      back_value  = last_ext[VALUE_W-1:0];
    end
  end

  assign entry_count = count;
  assign is_empty    = empty;
  assign status      = status_q;

endmodule

// ===== rtl/core/deque_ring_buffer_core.sv =====
`timescale 1ns / 1ps
// Top level of the double-ended queue core: controller plus datapath.
// Depends on deq_pkg, deq_ctrl, deq_dp (and through it deq_ram).
//
// Usage:
//   Drive command and data_value and raise start. The request is taken at a
//   rising edge where start is high and busy is low. Commands: push front,
//   push back, pop front, pop back, reverse, report only.
//   Exactly one result follows each request: front_value, back_value,
//   entry_count, is_empty and status are valid for the single cycle in
//   which done is high, after the exec and read states have run.
//   Steps: the exec state moves the ring pointers and writes the pushed
//   slot, the read state reads both end slots from the RAM (registered
//   read), and the done state shows the result. A new request may be taken
//   at the edge that ends the done cycle, so the block does not take a new
//   request before the result of the last one is shown.
//   The receiver cannot stall: it must take the result while done is high.
//   Reset (rst, synchronous) empties the queue, clears the direction bit
//   and returns the controller to idle; slot contents are not cleared.
//   Push when full reports status 1, pop when empty reports status 2, and
//   neither changes the queue.
module deque_ring_buffer_core #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output logic                          done,
  input  logic [deq_pkg::CMD_W-1:0]     command,
  input  logic [deq_pkg::VALUE_W-1:0]   data_value,
  output logic [deq_pkg::VALUE_W-1:0]   front_value,
  output logic [deq_pkg::VALUE_W-1:0]   back_value,
  output logic [$clog2(DEPTH+1)-1:0]    entry_count,
  output logic                          is_empty,
  output logic [deq_pkg::STATUS_W-1:0]  status
);

  import deq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  // Command strobes from the controller to the datapath.
  deq_cmd_t dp_cmd;

  deq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .dp_cmd (dp_cmd)
  );

  deq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .command     (command),
    .data_value  (data_value),
    .front_value (front_value),
    .back_value  (back_value),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .status      (status)
  );

  // Every accepted request produces its result strobe after the exec and read states.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result strobe missing three cycles after request");

  // A rejected push can only happen on a full queue.
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_FULL) |-> (entry_count == CntW'(DEPTH)))
    else $error("push rejected while queue not full");

  // A rejected pop can only happen on an empty queue.
  a_empty_reject: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_POP_EMPTY) |-> is_empty)
    else $error("pop rejected while queue not empty");

  // Count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count <= CntW'(DEPTH)))
    else $error("entry count above capacity");

endmodule

// ===== sim/deque_ring_buffer_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for deque_ring_buffer_core: directed table, then biased random requests.
// Depends on deq_pkg and the RTL of the core; results are checked against an in-bench model.
module deque_ring_buffer_core_test;
  import deq_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEF;
  localparam int COUNT_W    = $clog2(RING_DEPTH + 1);
  localparam int SLOT_W     = $clog2(RING_DEPTH);

  // Spare command codes; the core must treat them as report only.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 312;
  localparam int QUIET_TAIL      = 60;

  typedef struct packed {
    logic [VALUE_W-1:0]  front;
    logic [VALUE_W-1:0]  back;
    logic [COUNT_W-1:0]  count;
    logic                empty;
    logic [STATUS_W-1:0] stat;
  } queue_view_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] val;
    int                 reps;
    bit                 typed;
    queue_view_t        view;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  done;
  logic [CMD_W-1:0]      command;
  logic [VALUE_W-1:0]    data_value;
  logic [VALUE_W-1:0]    front_value;
  logic [VALUE_W-1:0]    back_value;
  logic [COUNT_W-1:0]    entry_count;
  logic                  is_empty;
  logic [STATUS_W-1:0]   status;

  // Bench copy of the ring: slots, physical head, occupancy and direction bit.
  logic [VALUE_W-1:0] ring_slot [RING_DEPTH];
  logic [SLOT_W-1:0]  ring_head;
  logic [COUNT_W-1:0] ring_count;
  logic               ring_reversed;

  queue_view_t expected_views[$];
  int          error_count;
  stim_row_t   directed_rows[22];

  deque_ring_buffer_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .command    (command),
    .data_value (data_value),
    .front_value(front_value),
    .back_value (back_value),
    .entry_count(entry_count),
    .is_empty   (is_empty),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the core hangs or drops a result.
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Apply one request to the bench ring and return the view the core must report.
  function automatic queue_view_t apply_request(input logic [CMD_W-1:0] cmd,
                                                input logic [VALUE_W-1:0] val);
    queue_view_t        view;
    logic               at_first;
    logic [VALUE_W-1:0] first_val;
    logic [VALUE_W-1:0] last_val;
    view      = '0;
    first_val = '0;
    last_val  = '0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (ring_count >= RING_DEPTH) begin
          view.stat = STAT_FULL;
        end else begin
          // Reversal swaps which physical end a front push lands on.
          at_first = (cmd == CMD_PUSH_FRONT) != ring_reversed;
          if (at_first) begin
            ring_head = ring_head - SLOT_W'(1);
            ring_slot[ring_head] = val;
          end else begin
            ring_slot[SLOT_W'(COUNT_W'(ring_head) + ring_count)] = val;
          end
          ring_count = ring_count + COUNT_W'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (ring_count == 0) begin
          view.stat = STAT_POP_EMPTY;
        end else begin
          at_first = (cmd == CMD_POP_FRONT) != ring_reversed;
          if (at_first) ring_head = ring_head + SLOT_W'(1);
          ring_count = ring_count - COUNT_W'(1);
        end
      end
      CMD_REVERSE: ring_reversed = ~ring_reversed;
      default: ;
    endcase
    if (ring_count != 0) begin
      first_val = ring_slot[ring_head];
      last_val  = ring_slot[SLOT_W'(COUNT_W'(ring_head) + ring_count - COUNT_W'(1))];
    end
    view.front = ring_reversed ? last_val : first_val;
    view.back  = ring_reversed ? first_val : last_val;
    view.count = ring_count;
    view.empty = (ring_count == 0);
    return view;
  endfunction

  // Present one request, optionally after an idle burst, and hold it until taken.
  // Keep start high between back-to-back requests so it never toggles within one step.
  task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                               input bit quiet, input bit typed, input queue_view_t typed_view);
    queue_view_t predicted;
    int          gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    command    <= cmd;
    data_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Taken at this edge: advance the bench ring now, since the result follows in order.
    predicted = apply_request(cmd, val);
    expected_views.push_back(typed ? typed_view : predicted);
  endtask

  // Check every result against the oldest outstanding expectation.
  always @(posedge clk) begin
    queue_view_t want;
    if (!rst && done) begin
      if (expected_views.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = expected_views.pop_front();
        if (front_value !== want.front) begin
          $error("front_value expected %h got %h", want.front, front_value);
          error_count++;
        end
        if (back_value !== want.back) begin
          $error("back_value expected %h got %h", want.back, back_value);
          error_count++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count expected %0d got %0d", want.count, entry_count);
          error_count++;
        end
        if (is_empty !== want.empty) begin
          $error("is_empty expected %b got %b", want.empty, is_empty);
          error_count++;
        end
        if (status !== want.stat) begin
          $error("status expected %0d got %0d", want.stat, status);
          error_count++;
        end
      end
    end
  end

  initial begin
    int               phase_left;
    bit               fill_phase;
    int               pick;
    logic [CMD_W-1:0] cmd;
    logic [VALUE_W-1:0] val;

    error_count   = 0;
    ring_head     = '0;
    ring_count    = '0;
    ring_reversed = 1'b0;
    rst        <= 1'b1;
    start      <= 1'b0;
    command    <= CMD_REPORT;
    data_value <= '0;

    // Typed rows are read straight off an empty or single-entry queue;
    // the rest go through the bench model. Fill to full, reject, drain, wrap the head.
    directed_rows = '{
      '{CMD_POP_FRONT,  32'h0,        1,  1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, STAT_POP_EMPTY}},
      '{CMD_POP_BACK,   32'h0,        1,  1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, STAT_POP_EMPTY}},
      '{CMD_REPORT,     32'hFFFFFFFF, 1,  1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, STAT_DONE}},
      '{CMD_REVERSE,    32'h0,        1,  1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, STAT_DONE}},
      '{CMD_PUSH_FRONT, 32'hFFFFFFFF, 1,  1'b1,
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 5'd1, 1'b0, STAT_DONE}},
      '{CMD_POP_BACK,   32'h0,        1,  1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, STAT_DONE}},
      '{CMD_REVERSE,    32'h0,        1,  1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, STAT_DONE}},
      '{CMD_PUSH_BACK,  32'h0,        1,  1'b1, '{32'h0, 32'h0, 5'd1, 1'b0, STAT_DONE}},
      '{CMD_PUSH_FRONT, 32'h80000000, 1,  1'b0, '0},
      '{CMD_SPARE_HI,   32'h12345678, 1,  1'b0, '0},
      '{CMD_SPARE_LO,   32'h0,        1,  1'b0, '0},
      '{CMD_PUSH_BACK,  32'h10000000, 14, 1'b0, '0},
      '{CMD_PUSH_FRONT, 32'h00000005, 1,  1'b0, '0},
      '{CMD_PUSH_BACK,  32'h00000006, 1,  1'b0, '0},
      '{CMD_REVERSE,    32'h0,        1,  1'b0, '0},
      '{CMD_PUSH_FRONT, 32'h00000007, 1,  1'b0, '0},
      '{CMD_POP_FRONT,  32'h0,        3,  1'b0, '0},
      '{CMD_PUSH_BACK,  32'hA5A50000, 2,  1'b0, '0},
      '{CMD_POP_BACK,   32'h0,        16, 1'b0, '0},
      '{CMD_REVERSE,    32'h0,        1,  1'b0, '0},
      '{CMD_PUSH_FRONT, 32'h7FFFFFF0, 20, 1'b0, '0},
      '{CMD_POP_FRONT,  32'h0,        17, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].reps; i++) begin
        issue_request(directed_rows[r].cmd, directed_rows[r].val + i, 1'b0,
                      directed_rows[r].typed, directed_rows[r].view);
      end
    end

    // Random part: alternate fill-biased and drain-biased stretches so the ring
    // keeps hitting full and empty with the head wrapping both ways.
    fill_phase = 1'b1;
    phase_left = $urandom_range(20, 50);
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (phase_left == 0) begin
        fill_phase = ~fill_phase;
        phase_left = $urandom_range(20, 50);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (fill_phase) begin
        if (pick < 30)      cmd = CMD_PUSH_FRONT;
        else if (pick < 60) cmd = CMD_PUSH_BACK;
        else if (pick < 72) cmd = CMD_POP_FRONT;
        else if (pick < 84) cmd = CMD_POP_BACK;
        else if (pick < 92) cmd = CMD_REVERSE;
        else                cmd = CMD_WIDTH_PICK(pick);
      end else begin
        if (pick < 12)      cmd = CMD_PUSH_FRONT;
        else if (pick < 24) cmd = CMD_PUSH_BACK;
        else if (pick < 52) cmd = CMD_POP_FRONT;
        else if (pick < 80) cmd = CMD_POP_BACK;
        else if (pick < 90) cmd = CMD_REVERSE;
        else                cmd = CMD_WIDTH_PICK(pick);
      end
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase
      issue_request(cmd, val, n >= RANDOM_REQUESTS - QUIET_TAIL, 1'b0, '0);
    end
    start <= 1'b0;

    // Drain outstanding results, then keep watching done for strays.
    while (expected_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Map the tail of the pick range onto report and the two spare codes.
  function automatic logic [CMD_W-1:0] CMD_WIDTH_PICK(input int pick);
    case (pick % 3)
      0:       return CMD_REPORT;
      1:       return CMD_SPARE_LO;
      default: return CMD_SPARE_HI;
    endcase
  endfunction

endmodule

// ===== deque_ring_buffer_core.f =====
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_dp.sv
rtl/core/deque_ring_buffer_core.sv
sim/deque_ring_buffer_core_test.sv
